// ===== rtl/assert_macros.svh =====
// Assertion macros for the ellipse raster generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ERG_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ellipse raster generator: assertion failed");
`define ERG_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("ellipse raster generator: forbidden condition seen");
`else
`define ERG_ASSERT(label, clk, rst_n, prop)
`define ERG_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ===== rtl/erg_pkg.sv =====
// Shared constants and types of the ellipse raster generator.
package erg_pkg;

    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    localparam logic CFG_LINE_PITCH = 1'b0;
    localparam logic CFG_DRAW_VALUE = 1'b1;

    localparam int CENTER_BITS  = 12;
    localparam int RAD_BITS     = 11;
    localparam int WALK_BITS    = 32;
    localparam int PITCH_BITS   = 13;
    localparam int VALUE_BITS   = 8;
    localparam int ADDR_BITS    = 24;
    localparam int TWO_SQ_BITS  = 24;

    localparam logic [PITCH_BITS-1:0] PITCH_RESET = 13'd256;
    localparam logic [VALUE_BITS-1:0] VALUE_RESET = 8'd1;

    localparam int QDEPTH    = 2;
    localparam int QPTR_BITS = 1;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== rtl/erg_front.sv =====
// Command front end: decodes requests, runs the error-term walk and queues pixel records.
module erg_front
    import erg_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int ERR_BITS   = 40
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_accept,
    input  logic                      i_opcode,
    input  logic [CENTER_BITS-1:0]    i_center_x,
    input  logic [CENTER_BITS-1:0]    i_center_y,
    input  logic [RAD_BITS-1:0]       i_radius_x,
    input  logic [RAD_BITS-1:0]       i_radius_y,
    output logic                      o_idle,
    output logic                      o_push,
    output logic [4*COORD_BITS+1:0]   o_rec
);

    localparam int E2W = (ERR_BITS < 64) ? ERR_BITS + 1 : 64;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ARC  = 2'd1;
    localparam logic [1:0] PH_TIP  = 2'd2;
    localparam logic [1:0] PH_DONE = 2'd3;

    localparam logic [2:0] FS_IDLE = 3'd0;
    localparam logic [2:0] FS_MUL  = 3'd1;
    localparam logic [2:0] FS_SUM  = 3'd2;
    localparam logic [2:0] FS_UPD  = 3'd3;
    localparam logic [2:0] FS_ERR  = 3'd4;

    logic [2:0]                  r_fs, n_fs;
    logic [1:0]                  r_phase, n_phase;
    logic [COORD_BITS-1:0]       r_cc, r_cr;
    logic signed [WALK_BITS-1:0] r_wx;
    logic [WALK_BITS-1:0]        r_wy;
    logic [RAD_BITS-1:0]         r_tip, r_rad_a;
    logic [2*RAD_BITS-1:0]       r_aa, r_bb;
    logic signed [ERR_BITS-1:0]  r_xi, r_yi, r_err;
    logic [TWO_SQ_BITS-1:0]      r_tbs, r_tas;
    logic                        r_dx, r_dy;

    logic [31:0]                 cx32, cy32;
    logic signed [RAD_BITS+1:0]  one_m2a;
    logic signed [35:0]          xi_prod;
    logic signed [63:0]          xi_prod64;
    logic [63:0]                 aa64, tbs64, tas64;
    logic signed [ERR_BITS:0]    e2_full;
    logic signed [E2W-1:0]       e2, xi_ext, yi_ext;
    logic                        dx, dy;
    logic signed [ERR_BITS-1:0]  add_x, add_y;
    logic signed [WALK_BITS-1:0] wx_n;
    logic [WALK_BITS-1:0]        wy_n, wy_tip, wy_src;
    logic                        arc_leaves, arc_to_tip, tip_ends;
    logic                        step_tip;
    logic signed [31:0]          wx32;
    logic [31:0]                 wy32;
    logic [COORD_BITS-1:0]       xl, xh, yp, ym;
    logic                        rec_arc, rec_done;

    assign cx32 = {{(32-CENTER_BITS){1'b0}}, i_center_x};
    assign cy32 = {{(32-CENTER_BITS){1'b0}}, i_center_y};

    // Setup arithmetic: (1 - 2a) * b^2 and a^2, wrapped to the error width.
    assign one_m2a   = $signed((RAD_BITS+2)'(1)) - $signed({1'b0, r_rad_a, 1'b0});
    assign xi_prod   = one_m2a * $signed({1'b0, r_bb});
    assign xi_prod64 = 64'(xi_prod);
    assign aa64      = {{(64-2*RAD_BITS){1'b0}}, r_aa};
    assign tbs64     = {{(64-TWO_SQ_BITS){1'b0}}, r_tbs};
    assign tas64     = {{(64-TWO_SQ_BITS){1'b0}}, r_tas};

    // The doubled error is one bit wider than the error itself.
    assign e2_full = $signed({r_err, 1'b0});
    assign e2      = $signed(e2_full[E2W-1:0]);
    assign xi_ext  = E2W'(r_xi);
    assign yi_ext  = E2W'(r_yi);
    assign dx      = (e2 >= xi_ext);
    assign dy      = (yi_ext >= e2);

    assign add_x = r_dx ? r_xi : '0;
    assign add_y = r_dy ? r_yi : '0;
    assign wx_n  = r_wx + $signed({{(WALK_BITS-1){1'b0}}, r_dx});
    assign wy_n  = r_wy + {{(WALK_BITS-1){1'b0}}, r_dy};
    assign wy_tip = r_wy + {{(WALK_BITS-1){1'b0}}, 1'b1};

    assign arc_leaves = !wx_n[WALK_BITS-1] && (wx_n != '0);
    assign arc_to_tip = wy_n < {{(WALK_BITS-RAD_BITS){1'b0}}, r_tip};
    assign tip_ends   = wy_tip >= {{(WALK_BITS-RAD_BITS){1'b0}}, r_tip};

    assign step_tip = i_accept && (i_opcode == OP_STEP) && (r_phase == PH_TIP)
                      && (r_fs == FS_IDLE);

    // Arc records carry the walk position before the update, tip records after it.
    assign wy_src = (r_fs == FS_ERR) ? r_wy : wy_tip;
    assign wx32   = r_wx;
    assign wy32   = wy_src;
    assign yp     = r_cr + wy32[COORD_BITS-1:0];
    assign ym     = r_cr - wy32[COORD_BITS-1:0];
    assign xl     = (r_fs == FS_ERR) ? r_cc - wx32[COORD_BITS-1:0] : r_cc;
    assign xh     = (r_fs == FS_ERR) ? r_cc + wx32[COORD_BITS-1:0] : r_cc;
    assign rec_arc  = (r_fs == FS_ERR);
    assign rec_done = rec_arc ? (arc_leaves && !arc_to_tip) : tip_ends;

    assign o_rec  = {rec_arc, rec_done, xl, xh, yp, ym};
    assign o_push = (r_fs == FS_ERR) || step_tip;
    assign o_idle = (r_fs == FS_IDLE);

    always_comb begin
        n_fs    = r_fs;
        n_phase = r_phase;
        unique case (r_fs)
            FS_IDLE: begin
                if (i_accept) begin
                    if (i_opcode == OP_START) begin
                        n_fs    = FS_MUL;
                        n_phase = PH_ARC;
                    end else if (r_phase == PH_ARC) begin
                        n_fs = FS_UPD;
                    end else if (r_phase == PH_TIP && tip_ends) begin
                        n_phase = PH_DONE;
                    end
                end
            end
            FS_MUL: n_fs = FS_SUM;
            FS_SUM: n_fs = FS_IDLE;
            FS_UPD: n_fs = FS_ERR;
            FS_ERR: begin
                n_fs = FS_IDLE;
                if (arc_leaves) begin
                    n_phase = arc_to_tip ? PH_TIP : PH_DONE;
                end
            end
            default: begin
                n_fs = FS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs    <= FS_IDLE;
            r_phase <= PH_IDLE;
        end else begin
            r_fs    <= n_fs;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cc    <= '0;
            r_cr    <= '0;
            r_wx    <= '0;
            r_wy    <= '0;
            r_tip   <= '0;
            r_rad_a <= '0;
            r_aa    <= '0;
            r_bb    <= '0;
            r_xi    <= '0;
            r_yi    <= '0;
            r_err   <= '0;
            r_tbs   <= '0;
            r_tas   <= '0;
            r_dx    <= 1'b0;
            r_dy    <= 1'b0;
        end else begin
            unique case (r_fs)
                FS_IDLE: begin
                    if (i_accept && i_opcode == OP_START) begin
                        r_cc    <= cx32[COORD_BITS-1:0];
                        r_cr    <= cy32[COORD_BITS-1:0];
                        r_wx    <= -$signed({{(WALK_BITS-RAD_BITS){1'b0}}, i_radius_x});
                        r_wy    <= '0;
                        r_tip   <= i_radius_y;
                        r_rad_a <= i_radius_x;
                        r_aa    <= (2*RAD_BITS)'(i_radius_x) * (2*RAD_BITS)'(i_radius_x);
                        r_bb    <= (2*RAD_BITS)'(i_radius_y) * (2*RAD_BITS)'(i_radius_y);
                    end else if (step_tip) begin
                        r_wy <= wy_tip;
                    end
                end
                FS_MUL: begin
                    r_xi  <= xi_prod64[ERR_BITS-1:0];
                    r_yi  <= $signed(aa64[ERR_BITS-1:0]);
                    r_tbs <= {1'b0, r_bb, 1'b0};
                    r_tas <= {1'b0, r_aa, 1'b0};
                end
                FS_SUM: begin
                    r_err <= r_xi + r_yi;
                end
                FS_UPD: begin
                    r_dx <= dx;
                    r_dy <= dy;
                    if (dx) begin
                        r_xi <= r_xi + $signed(tbs64[ERR_BITS-1:0]);
                    end
                    if (dy) begin
                        r_yi <= r_yi + $signed(tas64[ERR_BITS-1:0]);
                    end
                end
                FS_ERR: begin
                    r_err <= r_err + add_x + add_y;
                    r_wx  <= wx_n;
                    r_wy  <= wy_n;
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/erg_queue.sv =====
// Short record queue between the command front end and the pixel back end.
module erg_queue
    import erg_pkg::*;
#(
    parameter int WIDTH = 50
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_q_stat          o_stat
);

    logic [WIDTH-1:0]     r_mem [QDEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_BITS:0]   r_count;

    assign o_data       = r_mem[r_rd_ptr];
    assign o_stat.full  = (r_count == (QPTR_BITS+1)'(QDEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    // The depth is a power of two, so the pointers simply wrap.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            priority if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== rtl/erg_back.sv =====
// Pixel back end: expands queued records into pixels and forms the linear address.
module erg_back
    import erg_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic [4*COORD_BITS+1:0] i_rec,
    input  t_q_stat                 i_stat,
    input  logic [PITCH_BITS-1:0]   i_line_pitch,
    input  logic [VALUE_BITS-1:0]   i_draw_value,
    output logic                    o_pop,
    output logic                    o_strobe,
    output logic [COORD_BITS-1:0]   o_pixel_x,
    output logic [COORD_BITS-1:0]   o_pixel_y,
    output logic [ADDR_BITS-1:0]    o_pixel_addr,
    output logic [VALUE_BITS-1:0]   o_pixel_value,
    output logic                    o_step_last,
    output logic                    o_ellipse_done
);

    localparam int CW = COORD_BITS;

    logic          rec_arc, rec_done;
    logic [CW-1:0] xl, xh, yp, ym;
    logic [1:0]    r_k;
    logic          have, last_k;
    logic [CW-1:0] sel_x, sel_y;

    logic          r_pv, r_last, r_done;
    logic [CW-1:0] r_px, r_py;
    logic [31:0]   pitch32, px32, py32, addr_full;

    assign rec_arc  = i_rec[4*CW+1];
    assign rec_done = i_rec[4*CW];
    assign xl       = i_rec[4*CW-1:3*CW];
    assign xh       = i_rec[3*CW-1:2*CW];
    assign yp       = i_rec[2*CW-1:CW];
    assign ym       = i_rec[CW-1:0];

    // Arc order: (xl, yp), (xh, yp), (xh, ym), (xl, ym); a tip record gives two pixels.
    assign have   = !i_stat.empty;
    assign last_k = rec_arc ? (r_k == 2'd3) : (r_k == 2'd1);
    assign o_pop  = have && last_k;

    always_comb begin
        if (rec_arc) begin
            sel_x = (r_k == 2'd1 || r_k == 2'd2) ? xh : xl;
            sel_y = r_k[1] ? ym : yp;
        end else begin
            sel_x = xl;
            sel_y = r_k[0] ? ym : yp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k      <= '0;
            r_pv     <= 1'b0;
            o_strobe <= 1'b0;
        end else begin
            if (o_pop) begin
                r_k <= '0;
            end else if (have) begin
                r_k <= r_k + 1'b1;
            end
            r_pv     <= have;
            o_strobe <= r_pv;
        end
    end

    assign pitch32   = {{(32-PITCH_BITS){1'b0}}, i_line_pitch};
    assign px32      = {{(32-CW){1'b0}}, r_px};
    assign py32      = {{(32-CW){1'b0}}, r_py};
    assign addr_full = pitch32 * py32 + px32;

    always_ff @(posedge i_clk) begin
        r_px           <= sel_x;
        r_py           <= sel_y;
        r_last         <= last_k;
        r_done         <= last_k && rec_done;
        o_pixel_x      <= r_px;
        o_pixel_y      <= r_py;
        o_pixel_addr   <= addr_full[ADDR_BITS-1:0];
        o_pixel_value  <= i_draw_value;
        o_step_last    <= r_last;
        o_ellipse_done <= r_done;
    end

endmodule

// ===== rtl/ellipse_raster_generator.sv =====
// Top level of the ellipse raster generator: request port, configuration port and pixel strobe.
//
// A request is taken at a rising edge with start high and busy low. Opcode start loads the
// centre and the two radii; the set-up multiplications keep busy high through the multiply and
// sum states and no pixel is produced. Opcode step advances the walk by one iteration: on the arc
// it yields four pixels, in the tip phase of a narrow ellipse two, and after the final pixel
// (flagged by o_ellipse_done) nothing.
// The front end runs an arc step through its update and error states and a tip step straight
// from idle, and hands each step to a two-entry record queue. The back end turns each record
// into pixels at one pixel per cycle, so the single pixel port sets the sustained rate. A pixel
// passes the queue, a selection register and an output register before it appears;
// busy also rises while the queue is full.
// Each pixel is on the outputs for exactly one cycle, marked by o_strobe; the receiver cannot
// hold pixels off. o_step_last marks the last pixel of a step.
// Configuration writes (index 0 line pitch, index 1 draw value) are taken whenever
// i_cfg_valid is high and should only be made while the block is idle.
// Reset is synchronous and active low: the walk returns to idle, the queue empties, the line
// pitch becomes 256 and the draw value 1.
`include "assert_macros.svh"

module ellipse_raster_generator
    import erg_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int ERR_BITS   = 40
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic                   i_opcode,
    input  logic [CENTER_BITS-1:0] i_center_x,
    input  logic [CENTER_BITS-1:0] i_center_y,
    input  logic [RAD_BITS-1:0]    i_radius_x,
    input  logic [RAD_BITS-1:0]    i_radius_y,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic                   i_cfg_index,
    input  logic [PITCH_BITS-1:0]  i_cfg_data,
    output logic                   o_strobe,
    output logic [COORD_BITS-1:0]  o_pixel_x,
    output logic [COORD_BITS-1:0]  o_pixel_y,
    output logic [ADDR_BITS-1:0]   o_pixel_addr,
    output logic [VALUE_BITS-1:0]  o_pixel_value,
    output logic                   o_step_last,
    output logic                   o_ellipse_done
);

    localparam int REC_BITS = 4*COORD_BITS + 2;

    logic [PITCH_BITS-1:0] r_line_pitch;
    logic [VALUE_BITS-1:0] r_draw_value;

    logic                accept;
    logic                front_idle;
    logic                q_push, q_pop;
    logic [REC_BITS-1:0] q_in, q_out;
    t_q_stat             q_stat;

    assign o_cfg_ready = 1'b1;
    assign busy        = !front_idle || q_stat.full;
    assign accept      = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_pitch <= PITCH_RESET;
            r_draw_value <= VALUE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_LINE_PITCH: r_line_pitch <= i_cfg_data;
                CFG_DRAW_VALUE: r_draw_value <= i_cfg_data[VALUE_BITS-1:0];
                default: begin
                end
            endcase
        end
    end

    erg_front #(
        .COORD_BITS (COORD_BITS),
        .ERR_BITS   (ERR_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_opcode   (i_opcode),
        .i_center_x (i_center_x),
        .i_center_y (i_center_y),
        .i_radius_x (i_radius_x),
        .i_radius_y (i_radius_y),
        .o_idle     (front_idle),
        .o_push     (q_push),
        .o_rec      (q_in)
    );

    erg_queue #(
        .WIDTH (REC_BITS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_stat  (q_stat)
    );

    erg_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rec          (q_out),
        .i_stat         (q_stat),
        .i_line_pitch   (r_line_pitch),
        .i_draw_value   (r_draw_value),
        .o_pop          (q_pop),
        .o_strobe       (o_strobe),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_addr   (o_pixel_addr),
        .o_pixel_value  (o_pixel_value),
        .o_step_last    (o_step_last),
        .o_ellipse_done (o_ellipse_done)
    );

    // A start request must hold off further requests while the set-up runs.
    `ERG_ASSERT(a_start_holds_busy, i_clk, i_rst_n, (accept && i_opcode == OP_START) |=> busy)
    `ERG_NEVER(a_no_push_when_full, i_clk, i_rst_n, q_push && q_stat.full && !q_pop)
    `ERG_NEVER(a_no_pop_when_empty, i_clk, i_rst_n, q_pop && q_stat.empty)
    `ERG_ASSERT(a_done_on_step_end, i_clk, i_rst_n, (o_strobe && o_ellipse_done) |-> o_step_last)

endmodule

// ===== tb/ellipse_raster_checker.sv =====
// Pixel checker for the ellipse raster generator: predicts every pixel of each request and compares.
module ellipse_raster_checker
    import erg_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int ERR_BITS   = 40
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_busy,
    input  logic                   i_opcode,
    input  logic [CENTER_BITS-1:0] i_center_x,
    input  logic [CENTER_BITS-1:0] i_center_y,
    input  logic [RAD_BITS-1:0]    i_radius_x,
    input  logic [RAD_BITS-1:0]    i_radius_y,
    input  logic                   i_cfg_valid,
    input  logic                   i_cfg_ready,
    input  logic                   i_cfg_index,
    input  logic [PITCH_BITS-1:0]  i_cfg_data,
    input  logic                   i_strobe,
    input  logic [COORD_BITS-1:0]  i_pixel_x,
    input  logic [COORD_BITS-1:0]  i_pixel_y,
    input  logic [ADDR_BITS-1:0]   i_pixel_addr,
    input  logic [VALUE_BITS-1:0]  i_pixel_value,
    input  logic                   i_step_last,
    input  logic                   i_ellipse_done,
    output int                     o_pending,
    output int                     o_fail_count
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        WALK_IDLE,
        WALK_ARC,
        WALK_TIP,
        WALK_DONE
    } t_walk_phase;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [ADDR_BITS-1:0]  addr;
        logic [VALUE_BITS-1:0] value;
        logic                  last;
        logic                  done;
    } t_pixel;

    t_pixel pixels_due[$];
    t_pixel due;
    int     mismatches;

    logic [PITCH_BITS-1:0]      line_pitch;
    logic [VALUE_BITS-1:0]      draw_value;
    t_walk_phase                walk_phase;
    logic [COORD_BITS-1:0]      centre_col;
    logic [COORD_BITS-1:0]      centre_row;
    int                         walk_x;
    int                         walk_y;
    int                         tip_limit;
    logic signed [ERR_BITS-1:0] x_inc;
    logic signed [ERR_BITS-1:0] y_inc;
    logic signed [ERR_BITS-1:0] err_acc;
    logic [TWO_SQ_BITS-1:0]     two_b_sq;
    logic [TWO_SQ_BITS-1:0]     two_a_sq;

    assign o_fail_count = mismatches;

    function automatic t_pixel make_pixel(input int px, input int py);
        t_pixel      pix;
        logic [31:0] linear;
        pix.x = px[COORD_BITS-1:0];
        pix.y = py[COORD_BITS-1:0];
        linear = 32'(pix.x) + 32'(line_pitch) * 32'(pix.y);
        pix.addr = linear[ADDR_BITS-1:0];
        pix.value = draw_value;
        pix.last = 1'b0;
        pix.done = 1'b0;
        return pix;
    endfunction

    task automatic take_request(input logic op, input logic [CENTER_BITS-1:0] cx,
                                input logic [CENTER_BITS-1:0] cy, input logic [RAD_BITS-1:0] rx,
                                input logic [RAD_BITS-1:0] ry);
        t_pixel                   step_pixels[4];
        int                       n;
        bit                       finished;
        logic signed [ERR_BITS:0] doubled;
        longint                   a;
        longint                   b;
        n = 0;
        finished = 1'b0;
        a = longint'(rx);
        b = longint'(ry);
        if (op == OP_START) begin
            centre_col = COORD_BITS'(cx);
            centre_row = COORD_BITS'(cy);
            walk_x = -int'(rx);
            walk_y = 0;
            tip_limit = int'(ry);
            two_b_sq = TWO_SQ_BITS'(2 * b * b);
            two_a_sq = TWO_SQ_BITS'(2 * a * a);
            x_inc = ERR_BITS'((1 - 2 * a) * b * b);
            y_inc = ERR_BITS'(a * a);
            err_acc = x_inc + y_inc;
            walk_phase = WALK_ARC;
            return;
        end
        case (walk_phase)
            WALK_ARC: begin
                step_pixels[0] = make_pixel(int'(centre_col) - walk_x, int'(centre_row) + walk_y);
                step_pixels[1] = make_pixel(int'(centre_col) + walk_x, int'(centre_row) + walk_y);
                step_pixels[2] = make_pixel(int'(centre_col) + walk_x, int'(centre_row) - walk_y);
                step_pixels[3] = make_pixel(int'(centre_col) - walk_x, int'(centre_row) - walk_y);
                n = 4;
                // Both tests use the doubled error from before either update.
                doubled = {err_acc, 1'b0};
                if (doubled >= x_inc) begin
                    walk_x++;
                    x_inc = x_inc + ERR_BITS'($signed({1'b0, two_b_sq}));
                    err_acc = err_acc + x_inc;
                end
                if (y_inc >= doubled) begin
                    walk_y++;
                    y_inc = y_inc + ERR_BITS'($signed({1'b0, two_a_sq}));
                    err_acc = err_acc + y_inc;
                end
                if (walk_x > 0) begin
                    if (walk_y < tip_limit) begin
                        walk_phase = WALK_TIP;
                    end else begin
                        walk_phase = WALK_DONE;
                        finished = 1'b1;
                    end
                end
            end
            WALK_TIP: begin
                walk_y++;
                step_pixels[0] = make_pixel(int'(centre_col), int'(centre_row) + walk_y);
                step_pixels[1] = make_pixel(int'(centre_col), int'(centre_row) - walk_y);
                n = 2;
                if (walk_y >= tip_limit) begin
                    walk_phase = WALK_DONE;
                    finished = 1'b1;
                end
            end
            default: ;
        endcase
        if (n > 0) begin
            step_pixels[n-1].last = 1'b1;
            step_pixels[n-1].done = finished;
            for (int k = 0; k < n; k++) begin
                pixels_due.push_back(step_pixels[k]);
            end
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pixels_due.delete();
            line_pitch = PITCH_RESET;
            draw_value = VALUE_RESET;
            walk_phase = WALK_IDLE;
            centre_col = '0;
            centre_row = '0;
            walk_x = 0;
            walk_y = 0;
            tip_limit = 0;
            x_inc = '0;
            y_inc = '0;
            err_acc = '0;
            two_b_sq = '0;
            two_a_sq = '0;
        end else begin
            // Pixels on the port at this edge belong to earlier requests, so compare first.
            if (i_strobe) begin
                if (pixels_due.size() == 0) begin
                    $error("pixel strobe with no pixel due: x=%0d y=%0d", i_pixel_x, i_pixel_y);
                    mismatches++;
                end else begin
                    due = pixels_due.pop_front();
                    check_field("pixel_x", 32'(due.x), 32'(i_pixel_x));
                    check_field("pixel_y", 32'(due.y), 32'(i_pixel_y));
                    check_field("pixel_addr", 32'(due.addr), 32'(i_pixel_addr));
                    check_field("pixel_value", 32'(due.value), 32'(i_pixel_value));
                    check_field("step_last", 32'(due.last), 32'(i_step_last));
                    check_field("ellipse_done", 32'(due.done), 32'(i_ellipse_done));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_LINE_PITCH: line_pitch = i_cfg_data;
                    CFG_DRAW_VALUE: draw_value = i_cfg_data[VALUE_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                take_request(i_opcode, i_center_x, i_center_y, i_radius_x, i_radius_y);
            end
        end
        o_pending <= pixels_due.size();
    end

endmodule

// ===== tb/tb_ellipse_raster_generator.sv =====
// Testbench top of the ellipse raster generator: clock, reset, requests, register writes and verdict.
module tb_ellipse_raster_generator;
    import erg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_BITS   = 12;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_ITEMS  = 22;
    localparam int LAST_PHASE   = 7;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic                   i_opcode = OP_START;
    logic [CENTER_BITS-1:0] i_center_x = '0;
    logic [CENTER_BITS-1:0] i_center_y = '0;
    logic [RAD_BITS-1:0]    i_radius_x = '0;
    logic [RAD_BITS-1:0]    i_radius_y = '0;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic                   i_cfg_index = CFG_LINE_PITCH;
    logic [PITCH_BITS-1:0]  i_cfg_data = '0;
    logic                   o_strobe;
    logic [COORD_BITS-1:0]  o_pixel_x;
    logic [COORD_BITS-1:0]  o_pixel_y;
    logic [ADDR_BITS-1:0]   o_pixel_addr;
    logic [VALUE_BITS-1:0]  o_pixel_value;
    logic                   o_step_last;
    logic                   o_ellipse_done;

    int pixels_pending;
    int pixel_failures;
    int requests_sent = 0;
    int stall_cycles = 0;
    bit gaps_enabled = 1'b1;
    bit quiet_tail = 1'b0;

    always #2 i_clk = ~i_clk;

    ellipse_raster_generator #(
        .COORD_BITS(COORD_BITS),
        .ERR_BITS  (40)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_opcode      (i_opcode),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_radius_x    (i_radius_x),
        .i_radius_y    (i_radius_y),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_strobe      (o_strobe),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_pixel_addr  (o_pixel_addr),
        .o_pixel_value (o_pixel_value),
        .o_step_last   (o_step_last),
        .o_ellipse_done(o_ellipse_done)
    );

    ellipse_raster_checker #(
        .COORD_BITS(COORD_BITS),
        .ERR_BITS  (40)
    ) pixel_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_busy        (busy),
        .i_opcode      (i_opcode),
        .i_center_x    (i_center_x),
        .i_center_y    (i_center_y),
        .i_radius_x    (i_radius_x),
        .i_radius_y    (i_radius_y),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_strobe      (o_strobe),
        .i_pixel_x     (o_pixel_x),
        .i_pixel_y     (o_pixel_y),
        .i_pixel_addr  (o_pixel_addr),
        .i_pixel_value (o_pixel_value),
        .i_step_last   (o_step_last),
        .i_ellipse_done(o_ellipse_done),
        .o_pending     (pixels_pending),
        .o_fail_count  (pixel_failures)
    );

    // Any accepted request, register write or pixel restarts the stall count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_request(input logic op, input logic [CENTER_BITS-1:0] cx,
                                input logic [CENTER_BITS-1:0] cy, input logic [RAD_BITS-1:0] rx,
                                input logic [RAD_BITS-1:0] ry);
        if (gaps_enabled && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        start <= 1'b1;
        i_opcode <= op;
        i_center_x <= cx;
        i_center_y <= cy;
        i_radius_x <= rx;
        i_radius_y <= ry;
        do @(posedge i_clk); while (busy);
        requests_sent++;
    endtask

    task automatic draw_ellipse(input logic [CENTER_BITS-1:0] cx, input logic [CENTER_BITS-1:0] cy,
                                input logic [RAD_BITS-1:0] rx, input logic [RAD_BITS-1:0] ry,
                                input int steps);
        send_request(OP_START, cx, cy, rx, ry);
        repeat (steps) send_request(OP_STEP, CENTER_BITS'($urandom), CENTER_BITS'($urandom),
                                    RAD_BITS'($urandom), RAD_BITS'($urandom));
    endtask

    task automatic random_ellipse();
        logic [RAD_BITS-1:0] rx;
        logic [RAD_BITS-1:0] ry;
        int                  steps;
        int                  kind;
        kind = int'($urandom_range(0, 9));
        gaps_enabled = !quiet_tail && ($urandom_range(0, 2) != 0);
        rx = RAD_BITS'($urandom_range(0, 6));
        ry = RAD_BITS'($urandom_range(0, 6));
        if (kind == 2 || kind == 3) begin
            // Narrow and tall, so the walk ends on the centre column.
            rx = RAD_BITS'($urandom_range(0, 2));
            ry = RAD_BITS'($urandom_range(6, 16));
        end
        steps = int'(rx) + int'(ry) + int'($urandom_range(1, 3));
        if (kind == 1) begin
            steps = int'($urandom_range(0, steps - 1));
        end else if (kind == 0) begin
            // Full-size radii: a few steps only, then the next start abandons the walk.
            rx = RAD_BITS'($urandom);
            ry = RAD_BITS'($urandom);
            steps = int'($urandom_range(1, 6));
        end
        draw_ellipse(CENTER_BITS'($urandom), CENTER_BITS'($urandom), rx, ry, steps);
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge i_clk);
        while (pixels_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [PITCH_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    initial begin
        int                    phase_end;
        logic [PITCH_BITS-1:0] pitch_setting;
        logic [VALUE_BITS-1:0] value_setting;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed requests under the reset register values.
        send_request(OP_STEP, 12'hFFF, 12'hFFF, 11'h7FF, 11'h7FF);
        draw_ellipse(12'd0, 12'd0, 11'd0, 11'd0, 2);
        draw_ellipse(12'hFFF, 12'hFFF, 11'd0, 11'd2, 4);
        draw_ellipse(12'd2048, 12'd100, 11'd3, 11'd0, 5);
        draw_ellipse(12'hFFF, 12'd0, 11'h7FF, 11'h7FF, 3);
        draw_ellipse(12'd10, 12'hFFF, 11'd1, 11'd1, 4);

        for (int p = 1; p <= LAST_PHASE; p++) begin
            settle();
            case (p)
                1: begin pitch_setting = 13'd0;    value_setting = 8'hFF; end
                2: begin pitch_setting = 13'd4096; value_setting = 8'h00; end
                3: begin pitch_setting = 13'd1;    value_setting = 8'hAA; end
                4: begin pitch_setting = 13'h1FFF; value_setting = 8'h55; end
                default: begin
                    pitch_setting = PITCH_BITS'($urandom_range(1, 4096));
                    value_setting = VALUE_BITS'($urandom);
                end
            endcase
            write_reg(CFG_LINE_PITCH, pitch_setting);
            write_reg(CFG_DRAW_VALUE, {5'($urandom), value_setting});
            i_cfg_valid <= 1'b0;
            quiet_tail = (p == LAST_PHASE);
            phase_end = requests_sent + PHASE_ITEMS;
            while (requests_sent < phase_end) random_ellipse();
        end

        settle();
        if (pixel_failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== ellipse_raster_generator.f =====
+incdir+rtl
rtl/erg_pkg.sv
rtl/erg_front.sv
rtl/erg_queue.sv
rtl/erg_back.sv
rtl/ellipse_raster_generator.sv
tb/ellipse_raster_checker.sv
tb/tb_ellipse_raster_generator.sv
